// ===== sv/bmhp_pkg.sv =====
// Shared widths, reset values and register indexes for the block matcher.
// No dependencies; block_match_haar_pair refers to it by scoped names.
package bmhp_pkg;

    // Geometry and parameter defaults
    localparam int MAX_PADDED_ROWS_DEF = 1024;
    localparam int PIXEL_BITS_DEF      = 12;
    localparam int MAX_PADDED_COLS     = 4096;
    localparam int MAX_SHIFT           = 8;
    localparam int BORDER              = 4;

    // Configuration registers
    localparam int ROWS_W     = 11;
    localparam int COLS_W     = 13;
    localparam int SHIFT_W    = 4;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int ROWS_RST   = 68;
    localparam int COLS_RST   = 68;
    localparam int SHIFT_RST  = 0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PADDED_ROWS = 2'd0,
        CFG_PADDED_COLS = 2'd1,
        CFG_DIFF_SHIFT  = 2'd2
    } t_cfg_idx;

    // Counters and result fields
    localparam int COL_CNT_W   = 12;
    localparam int AVG_W       = 13;
    localparam int DIFF_W      = 21;
    localparam int OROW_W      = 10;
    localparam int OCOL_W      = 11;
    localparam int OUT_TDATA_W = 56;

    // Per-item control carried down the pipeline
    typedef struct packed {
        logic              emit;
        logic              last;
        logic [OROW_W-1:0] out_row;
        logic [OCOL_W-1:0] out_col;
    } t_meta;

endpackage

// ===== sv/block_match_haar_pair.sv =====
// 3x3 SAD block matcher with average / difference output over a padded plane.
// Uses bmhp_pkg for widths, reset values, register indexes and the meta struct.
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+-------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tdata: pixel
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata: avg,diff,row,col; tlast
//  cfg       | in        | i_cfg_valid/o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One item per cycle while not stalled; a result passes stages a to d and the output register.
// The row store is one memory word per padded row holding three columns; each item
// reads its row into stage a and writes it back from there, with a bypass for the same row.
// Active-low sync reset: config to defaults; counters, window, valid bits cleared; store kept.
// The pipeline stalls as a whole only when a result waits in the output register
// and another result is ready behind it.
module block_match_haar_pair #(
    parameter int MAX_PADDED_ROWS = bmhp_pkg::MAX_PADDED_ROWS_DEF,
    parameter int PIXEL_BITS      = bmhp_pkg::PIXEL_BITS_DEF,
    localparam int IN_TDATA_W     = ((PIXEL_BITS + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [IN_TDATA_W-1:0]               s_axis_tdata,  // pixel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // average, difference, out_row, out_col, zero fill
    output logic [bmhp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,  // frame_last
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bmhp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bmhp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PB   = PIXEL_BITS;
    localparam int RW   = $clog2(MAX_PADDED_ROWS);
    localparam int RCW  = $clog2(MAX_PADDED_ROWS + 1);
    localparam int RSW  = (RCW > bmhp_pkg::ROWS_W) ? RCW : bmhp_pkg::ROWS_W;
    localparam int CW   = bmhp_pkg::COLS_W;
    localparam int CNW  = bmhp_pkg::COL_CNT_W;
    localparam int WW   = 3 * PB;
    localparam int SW   = PB + 4;
    localparam int XW   = PB + 10;
    localparam int EW   = (XW > bmhp_pkg::DIFF_W) ? XW : bmhp_pkg::DIFF_W;
    localparam int AW   = (PB + 1 > bmhp_pkg::AVG_W) ? PB + 1 : bmhp_pkg::AVG_W;

    // ---------------- configuration ----------------
    logic [bmhp_pkg::ROWS_W-1:0]  r_padded_rows;
    logic [CW-1:0]                r_padded_cols;
    logic [bmhp_pkg::SHIFT_W-1:0] r_diff_shift;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_padded_rows <= bmhp_pkg::ROWS_W'(bmhp_pkg::ROWS_RST);
            r_padded_cols <= CW'(bmhp_pkg::COLS_RST);
            r_diff_shift  <= bmhp_pkg::SHIFT_W'(bmhp_pkg::SHIFT_RST);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bmhp_pkg::CFG_PADDED_ROWS: r_padded_rows <= i_cfg_data[bmhp_pkg::ROWS_W-1:0];
                bmhp_pkg::CFG_PADDED_COLS: r_padded_cols <= i_cfg_data[CW-1:0];
                bmhp_pkg::CFG_DIFF_SHIFT:  r_diff_shift  <= i_cfg_data[bmhp_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline enable ----------------
    logic            en;
    logic            accept;
    logic            r_d_v;
    bmhp_pkg::t_meta r_d_meta;
    logic            r_o_valid;

    assign en            = !(r_o_valid && !m_axis_tready && r_d_v && r_d_meta.emit);
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    // ---------------- position counters ----------------
    logic [RW-1:0]  r_row;
    logic [CNW-1:0] r_col;
    logic [1:0]     r_c3;     // r_col mod 3, the store slot of this column

    logic [RSW-1:0] rows_x, rows_eff, row_x, row_inc, row_m4;
    logic [CW-1:0]  cols_eff, col_x;
    logic [CNW-1:0] col_m4;
    logic           row_wrap, col_wrap;
    bmhp_pkg::t_meta meta_in;

    always_comb begin
        rows_x   = RSW'(r_padded_rows);
        rows_eff = (rows_x > RSW'(MAX_PADDED_ROWS)) ? RSW'(MAX_PADDED_ROWS) : rows_x;
        cols_eff = (r_padded_cols > CW'(bmhp_pkg::MAX_PADDED_COLS))
                 ? CW'(bmhp_pkg::MAX_PADDED_COLS) : r_padded_cols;
        row_x    = RSW'(r_row);
        row_inc  = row_x + RSW'(1);
        row_m4   = row_x - RSW'(bmhp_pkg::BORDER);
        col_x    = CW'(r_col);
        col_m4   = r_col - CNW'(bmhp_pkg::BORDER);
        row_wrap = (row_inc >= rows_eff);
        col_wrap = ((col_x + CW'(1)) >= cols_eff);

        // result at interior of every even unpadded-plus-pad column, two steps late
        meta_in.emit    = (row_x >= RSW'(bmhp_pkg::BORDER))
                       && (r_col >= CNW'(bmhp_pkg::BORDER))
                       && !r_col[0]
                       && ((col_x + CW'(2)) <= cols_eff);
        meta_in.last    = row_wrap && ((col_x + CW'(3)) >= cols_eff);
        meta_in.out_row = row_m4[bmhp_pkg::OROW_W-1:0];
        meta_in.out_col = col_m4[CNW-1:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_c3  <= 2'd0;
        end else if (accept) begin
            if (row_wrap) begin
                r_row <= '0;
                if (col_wrap) begin
                    r_col <= '0;
                    r_c3  <= 2'd0;
                end else begin
                    r_col <= r_col + CNW'(1);
                    r_c3  <= (r_c3 == 2'd2) ? 2'd0 : r_c3 + 2'd1;
                end
            end else begin
                r_row <= row_inc[RW-1:0];
            end
        end
    end

    // ---------------- stage a: row store read / write back ----------------
    logic [WW-1:0]   mem [0:MAX_PADDED_ROWS-1];
    logic [WW-1:0]   r_rd;
    logic            r_fwd;
    logic [WW-1:0]   r_fwd_data;
    logic            r_a_v;
    bmhp_pkg::t_meta r_a_meta;
    logic [PB-1:0]   r_a_px;
    logic [RW-1:0]   r_a_row;
    logic [1:0]      r_a_c3;

    logic [WW-1:0]   word, merged;
    logic [PB-1:0]   slot [0:2];
    logic [PB-1:0]   fresh [0:3];

    always_comb begin
        word = r_fwd ? r_fwd_data : r_rd;
        for (int k = 0; k < 3; k++) begin
            slot[k] = word[PB*k +: PB];
        end
        merged = word;
        case (r_a_c3)
            2'd0: begin
                fresh[0] = slot[0];
                fresh[1] = slot[1];
                fresh[2] = slot[2];
                merged[0 +: PB] = r_a_px;
            end
            2'd1: begin
                fresh[0] = slot[1];
                fresh[1] = slot[2];
                fresh[2] = slot[0];
                merged[PB +: PB] = r_a_px;
            end
            default: begin
                fresh[0] = slot[2];
                fresh[1] = slot[0];
                fresh[2] = slot[1];
                merged[2*PB +: PB] = r_a_px;
            end
        endcase
        fresh[3] = r_a_px;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd <= mem[r_row];
            if (r_a_v) begin
                mem[r_a_row] <= merged;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_fwd <= 1'b0;
        end else if (en) begin
            r_a_v <= accept;
            // same row written back in the edge it is read again
            r_fwd <= r_a_v && (r_a_row == r_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fwd_data <= merged;
            r_a_meta   <= meta_in;
            r_a_px     <= s_axis_tdata[PB-1:0];
            r_a_row    <= r_row;
            r_a_c3     <= r_c3;
        end
    end

    // ---------------- stage b: 4 x 5 window ----------------
    logic [PB-1:0]   r_win [0:3][0:4];
    logic            r_b_v;
    bmhp_pkg::t_meta r_b_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                for (int t = 0; t < 5; t++) begin
                    r_win[k][t] <= '0;
                end
            end
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= r_a_v;
            if (r_a_v) begin
                for (int k = 0; k < 4; k++) begin
                    for (int t = 0; t < 4; t++) begin
                        r_win[k][t] <= r_win[k][t+1];
                    end
                    r_win[k][4] <= fresh[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_meta <= r_a_meta;
        end
    end

    // ---------------- stage c: 27 absolute differences ----------------
    logic [PB-1:0]   ad [0:2][0:8];
    logic [PB-1:0]   r_c_ad [0:2][0:8];
    logic [PB-1:0]   r_c_m [0:2];
    logic [PB-1:0]   r_c_p;
    logic            r_c_v;
    bmhp_pkg::t_meta r_c_meta;

    always_comb begin
        for (int d = 0; d < 3; d++) begin
            for (int bi = 0; bi < 3; bi++) begin
                for (int bj = 0; bj < 3; bj++) begin
                    // candidate rows shifted by d-1, one column to the left
                    if (r_win[bj][d + bi] > r_win[bj + 1][bi + 1]) begin
                        ad[d][3*bi + bj] = r_win[bj][d + bi] - r_win[bj + 1][bi + 1];
                    end else begin
                        ad[d][3*bi + bj] = r_win[bj + 1][bi + 1] - r_win[bj][d + bi];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_ad   <= ad;
            for (int d = 0; d < 3; d++) begin
                r_c_m[d] <= r_win[1][d + 1];
            end
            r_c_p    <= r_win[2][2];
            r_c_meta <= r_b_meta;
        end
    end

    // ---------------- stage d: block sums ----------------
    logic [SW-1:0]   sums [0:2];
    logic [SW-1:0]   r_d_sum [0:2];
    logic [PB-1:0]   r_d_m [0:2];
    logic [PB-1:0]   r_d_p;

    always_comb begin
        for (int d = 0; d < 3; d++) begin
            sums[d] = '0;
            for (int e = 0; e < 9; e++) begin
                sums[d] = sums[d] + SW'(r_c_ad[d][e]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sum  <= sums;
            r_d_m    <= r_c_m;
            r_d_p    <= r_c_p;
            r_d_meta <= r_c_meta;
        end
    end

    // ---------------- selection and output arithmetic ----------------
    logic [SW-1:0]              sel_sum;
    logic [PB-1:0]              sel_m;
    logic [bmhp_pkg::SHIFT_W-1:0] sh, lsh;
    logic signed [XW-1:0]       dm, ds;
    logic signed [EW-1:0]       de;
    logic [AW-1:0]              av;

    always_comb begin
        // centre wins ties against the upper candidate; lower needs strictly less
        if (r_d_sum[1] <= r_d_sum[0]) begin
            sel_sum = r_d_sum[1];
            sel_m   = r_d_m[1];
        end else begin
            sel_sum = r_d_sum[0];
            sel_m   = r_d_m[0];
        end
        if (r_d_sum[2] < sel_sum) begin
            sel_sum = r_d_sum[2];
            sel_m   = r_d_m[2];
        end
        sh  = (r_diff_shift > bmhp_pkg::SHIFT_W'(bmhp_pkg::MAX_SHIFT))
            ? bmhp_pkg::SHIFT_W'(bmhp_pkg::MAX_SHIFT) : r_diff_shift;
        lsh = bmhp_pkg::SHIFT_W'(bmhp_pkg::MAX_SHIFT) - sh;
        dm  = $signed(XW'(sel_m)) - $signed(XW'(r_d_p));
        ds  = dm <<< lsh;
        de  = EW'(ds);
        av  = AW'(sel_m) + AW'(r_d_p);
    end

    // ---------------- output register ----------------
    logic [bmhp_pkg::AVG_W-1:0]  r_o_avg;
    logic [bmhp_pkg::DIFF_W-1:0] r_o_diff;
    logic [bmhp_pkg::OROW_W-1:0] r_o_row;
    logic [bmhp_pkg::OCOL_W-1:0] r_o_col;
    logic                        r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            if (en && r_d_v && r_d_meta.emit) begin
                r_o_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_d_v && r_d_meta.emit) begin
            r_o_avg  <= av[bmhp_pkg::AVG_W-1:0];
            r_o_diff <= de[bmhp_pkg::DIFF_W-1:0];
            r_o_row  <= r_d_meta.out_row;
            r_o_col  <= r_d_meta.out_col;
            r_o_last <= r_d_meta.last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {1'b0, r_o_col, r_o_row, r_o_diff, r_o_avg};
    assign m_axis_tlast  = r_o_last;

`ifndef NO_ASSERTIONS
    // only emitting items are sure to see a fully written window
    a_sel_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_v && r_d_meta.emit) |-> (sel_sum <= r_d_sum[0] && sel_sum <= r_d_sum[1]
                   && sel_sum <= r_d_sum[2]))
        else $error("selected SAD is not the minimum");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_v && r_d_meta.emit && r_o_valid && !m_axis_tready)
        |=> (r_d_v && r_d_meta.emit && $stable(r_d_meta)))
        else $error("pending result left stage d during a stall");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col == '0) |-> (r_c3 == 2'd0))
        else $error("column slot out of step with column counter");
`endif

endmodule

// ===== test/block_match_haar_pair_tb.sv =====
// Self-checking bench for block_match_haar_pair: streams whole padded frames of
// directed and random pixels, predicts every match result and checks the output.
// Depends on bmhp_pkg and the block_match_haar_pair RTL.
module block_match_haar_pair_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W       = bmhp_pkg::PIXEL_BITS_DEF;
    localparam int STORE_D     = bmhp_pkg::MAX_PADDED_ROWS_DEF;
    localparam int MAX_COLS    = bmhp_pkg::MAX_PADDED_COLS;
    localparam int MAX_SHIFT   = bmhp_pkg::MAX_SHIFT;
    localparam int BORDER      = bmhp_pkg::BORDER;
    localparam int ROWS_W      = bmhp_pkg::ROWS_W;
    localparam int COLS_W      = bmhp_pkg::COLS_W;
    localparam int SHIFT_W     = bmhp_pkg::SHIFT_W;
    localparam int CFG_DATA_W  = bmhp_pkg::CFG_DATA_W;
    localparam int CFG_IDX_W   = bmhp_pkg::CFG_IDX_W;
    localparam int AVG_W       = bmhp_pkg::AVG_W;
    localparam int DIFF_W      = bmhp_pkg::DIFF_W;
    localparam int OROW_W      = bmhp_pkg::OROW_W;
    localparam int OCOL_W      = bmhp_pkg::OCOL_W;
    localparam int OUT_W       = bmhp_pkg::OUT_TDATA_W;
    localparam int IN_W        = ((PIX_W + 7) / 8) * 8;
    localparam int DIFF_LO     = AVG_W;
    localparam int OROW_LO     = DIFF_LO + DIFF_W;
    localparam int OCOL_LO     = OROW_LO + OROW_W;
    localparam int PIX_MAX     = (1 << PIX_W) - 1;
    localparam int ROWS_HI_W   = CFG_DATA_W - ROWS_W;
    localparam int SHIFT_HI_W  = CFG_DATA_W - SHIFT_W;
    localparam int GAP_MAX     = 8;
    localparam int SETTLE      = 12;
    localparam int RAND_ITEMS  = 650;

    typedef struct packed {
        logic [AVG_W-1:0]  average;
        logic [DIFF_W-1:0] difference;
        logic [OROW_W-1:0] out_row;
        logic [OCOL_W-1:0] out_col;
        logic              frame_last;
    } t_match_result;

    typedef enum int {
        FILL_FLAT,
        FILL_CHECKER,
        FILL_DIAG3,
        FILL_NOISE,
        FILL_FEW,
        FILL_TWO,
        FILL_RAMP,
        FILL_DIAG_UP,
        FILL_DIAG_DOWN
    } t_fill;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;  // pixel, zero fill
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // average, difference, out_row, out_col, zero fill
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;        // frame_last
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    block_match_haar_pair u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Matcher state as seen by the bench
    logic [PIX_W-1:0]      col_mem [3][STORE_D];
    logic [PIX_W-1:0]      win [4][5];
    int unsigned           row_pos;
    int unsigned           col_pos;
    logic [ROWS_W-1:0]     rows_reg;
    logic [COLS_W-1:0]     cols_reg;
    logic [SHIFT_W-1:0]    shift_reg;

    t_match_result         pending_results[$];
    logic [PIX_W-1:0]      pixel_feed[$];
    logic [PIX_W-1:0]      tone [4];

    int                    fail_count = 0;
    int unsigned           fed_items  = 0;
    int                    src_gap_max = GAP_MAX;
    int                    sink_stall_max = GAP_MAX;
    bit                    pix_taken = 1'b0;
    bit                    pix_live  = 1'b0;
    int                    pix_wait  = 0;
    bit                    res_taken = 1'b0;
    int                    sink_wait = 0;

    function automatic int unsigned window_cost(int d);
        int unsigned sum;
        logic [PIX_W-1:0] a, b;
        sum = 0;
        for (int bi = -1; bi <= 1; bi++) begin
            for (int bj = -1; bj <= 1; bj++) begin
                a = win[1 + bj][2 + d + bi];
                b = win[2 + bj][2 + bi];
                sum += (a > b) ? 32'(a - b) : 32'(b - a);
            end
        end
        return sum;
    endfunction

    function automatic void match_predict(logic [PIX_W-1:0] px);
        int unsigned      rows, cols, r, c, best, cost, sh;
        logic [PIX_W-1:0] fresh [4];
        logic [PIX_W-1:0] m, p;
        bit               have;
        int               scale, diff;
        t_match_result    res;
        rows = (rows_reg > STORE_D) ? STORE_D : rows_reg;
        cols = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
        r = (row_pos >= STORE_D) ? 0 : row_pos;
        c = col_pos;
        // three previous columns of this row, then the new pixel
        fresh[0] = col_mem[c % 3][r];
        fresh[1] = col_mem[(c + 1) % 3][r];
        fresh[2] = col_mem[(c + 2) % 3][r];
        fresh[3] = px;
        col_mem[c % 3][r] = px;
        for (int k = 0; k < 4; k++) begin
            for (int t = 0; t < 4; t++)
                win[k][t] = win[k][t + 1];
            win[k][4] = fresh[k];
        end

        if (r >= BORDER && c >= BORDER && c % 2 == 0 && c + 2 <= cols) begin
            have = 1'b0;
            best = 0;
            m = '0;
            p = win[2][2];
            // centre takes ties, otherwise strictly smaller wins
            for (int d = -1; d <= 1; d++) begin
                cost = window_cost(d);
                if (!have || cost < best || (d == 0 && cost == best)) begin
                    have = 1'b1;
                    best = cost;
                    m = win[1][2 + d];
                end
            end
            sh = (shift_reg > MAX_SHIFT) ? MAX_SHIFT : shift_reg;
            scale = 1 << (MAX_SHIFT - sh);
            diff = (int'(m) - int'(p)) * scale;
            res.average    = AVG_W'(m) + AVG_W'(p);
            res.difference = diff[DIFF_W-1:0];
            res.out_row    = OROW_W'(r - BORDER);
            res.out_col    = OCOL_W'((c - BORDER) >> 1);
            res.frame_last = (r + 1 >= rows) && (c + 3 >= cols);
            pending_results.push_back(res);
        end

        if (r + 1 >= rows) begin
            row_pos = 0;
            col_pos = (c + 1 >= cols) ? 0 : (c + 1) % (1 << bmhp_pkg::COL_CNT_W);
        end else begin
            row_pos = r + 1;
            col_pos = c;
        end
    endfunction

    function automatic void cfg_apply(bmhp_pkg::t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            bmhp_pkg::CFG_PADDED_ROWS: rows_reg  = val[ROWS_W-1:0];
            bmhp_pkg::CFG_PADDED_COLS: cols_reg  = val[COLS_W-1:0];
            bmhp_pkg::CFG_DIFF_SHIFT:  shift_reg = val[SHIFT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] frame_pixel(t_fill fill, int unsigned r,
                                                     int unsigned c);
        case (fill)
            FILL_FLAT:      return tone[0];
            FILL_CHECKER:   return ((r + c) % 2 != 0) ? tone[1] : tone[0];
            FILL_DIAG3:     return tone[(r + c) % 3];
            FILL_FEW:       return PIX_W'(tone[0] + $urandom_range(0, 3));
            FILL_TWO:       return ($urandom_range(0, 1) != 0) ? PIX_W'(PIX_MAX) : '0;
            FILL_RAMP:      return PIX_W'(tone[0] + r * tone[1][3:0] + c * tone[2][3:0]
                                          + $urandom_range(0, 3));
            FILL_DIAG_UP:   return ($urandom_range(0, 15) == 0)
                                   ? PIX_W'($urandom_range(0, PIX_MAX)) : tone[(r + c) % 4];
            FILL_DIAG_DOWN: return ($urandom_range(0, 15) == 0)
                                   ? PIX_W'($urandom_range(0, PIX_MAX))
                                   : tone[(r + 3 * c) % 4];
            default:        return PIX_W'($urandom_range(0, PIX_MAX));
        endcase
    endfunction

    function automatic void field_check(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
        end
    endfunction

    // pixel side: accept at the rising edge, drive at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            match_predict(s_axis_tdata[PIX_W-1:0]);
            pix_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (pix_taken) begin
            pix_taken = 1'b0;
            pix_live  = 1'b0;
            pix_wait  = $urandom_range(0, src_gap_max);
        end
        if (!pix_live && i_rst_n) begin
            if (pix_wait > 0) begin
                pix_wait--;
            end else if (pixel_feed.size() != 0) begin
                s_axis_tdata <= IN_W'(pixel_feed.pop_front());
                pix_live = 1'b1;
            end
        end
        s_axis_tvalid <= pix_live;
    end

    // result side
    always @(posedge i_clk) begin
        t_match_result want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            res_taken = 1'b1;
            got.average    = m_axis_tdata[DIFF_LO-1:0];
            got.difference = m_axis_tdata[OROW_LO-1:DIFF_LO];
            got.out_row    = m_axis_tdata[OCOL_LO-1:OROW_LO];
            got.out_col    = m_axis_tdata[OCOL_LO+OCOL_W-1:OCOL_LO];
            got.frame_last = m_axis_tlast;
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t ns: result expected none got %0h", $time, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                field_check("average", 32'(want.average), 32'(got.average));
                field_check("difference", 32'(want.difference), 32'(got.difference));
                field_check("out_row", 32'(want.out_row), 32'(got.out_row));
                field_check("out_col", 32'(want.out_col), 32'(got.out_col));
                field_check("frame_last", 32'(want.frame_last), 32'(got.frame_last));
            end
        end
    end

    always @(negedge i_clk) begin
        if (res_taken) begin
            res_taken = 1'b0;
            sink_wait = $urandom_range(0, sink_stall_max);
        end
        if (sink_wait > 0) begin
            sink_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(bmhp_pkg::t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cfg_apply(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // block must be drained before registers change
    task automatic wait_idle();
        while (pixel_feed.size() != 0 || pix_live || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic send_frame(t_fill fill);
        int unsigned nr, nc;
        nr = (rows_reg == 0) ? 1 : ((rows_reg > STORE_D) ? STORE_D : rows_reg);
        nc = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
        for (int unsigned c = 0; c < nc; c++)
            for (int unsigned r = 0; r < nr; r++)
                pixel_feed.push_back(frame_pixel(fill, r, c));
        fed_items += nr * nc;
        wait_idle();
    endtask

    task automatic set_geometry(int unsigned rows, int unsigned cols, int unsigned shift);
        write_reg(bmhp_pkg::CFG_PADDED_ROWS, CFG_DATA_W'(rows));
        write_reg(bmhp_pkg::CFG_PADDED_COLS, CFG_DATA_W'(cols));
        write_reg(bmhp_pkg::CFG_DIFF_SHIFT, CFG_DATA_W'(shift));
    endtask

    initial begin
        int unsigned           nr, nc, rand_start;
        logic [CFG_DATA_W-1:0] word;
        t_fill                 fill;

        rows_reg  = ROWS_W'(bmhp_pkg::ROWS_RST);
        cols_reg  = COLS_W'(bmhp_pkg::COLS_RST);
        shift_reg = SHIFT_W'(bmhp_pkg::SHIFT_RST);
        row_pos   = 0;
        col_pos   = 0;
        for (int k = 0; k < 3; k++)
            for (int r = 0; r < STORE_D; r++)
                col_mem[k][r] = '0;
        for (int k = 0; k < 4; k++)
            for (int t = 0; t < 5; t++)
                win[k][t] = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // smallest plane with one result: flat (centre tie), checkerboard
        // (upper/lower tie goes up), diagonal (lower offset strictly best)
        set_geometry(5, 6, 15);
        tone = '{PIX_W'(PIX_MAX), '0, '0, '0};
        send_frame(FILL_FLAT);
        write_reg(bmhp_pkg::CFG_DIFF_SHIFT, CFG_DATA_W'(0));
        tone = '{'0, PIX_W'(PIX_MAX), '0, '0};
        send_frame(FILL_CHECKER);
        write_reg(bmhp_pkg::CFG_DIFF_SHIFT, CFG_DATA_W'(MAX_SHIFT));
        tone = '{'0, PIX_W'(PIX_MAX), PIX_W'(2048), '0};
        send_frame(FILL_DIAG3);

        rand_start = fed_items;
        while (fed_items - rand_start < RAND_ITEMS) begin
            src_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            case ($urandom_range(0, 9))
                0:       begin nr = $urandom_range(0, 4);  nc = $urandom_range(0, 12); end
                1:       begin nr = $urandom_range(0, 12); nc = $urandom_range(0, 5);  end
                default: begin nr = $urandom_range(5, 12); nc = $urandom_range(6, 16); end
            endcase
            word = CFG_DATA_W'(nr);
            if ($urandom_range(0, 7) == 0)
                word[CFG_DATA_W-1:ROWS_W] = ROWS_HI_W'($urandom_range(1, 3));
            write_reg(bmhp_pkg::CFG_PADDED_ROWS, word);
            write_reg(bmhp_pkg::CFG_PADDED_COLS, CFG_DATA_W'(nc));
            if ($urandom_range(0, 1) == 0) begin
                word = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(9, 15)
                                                               : $urandom_range(0, MAX_SHIFT));
                if ($urandom_range(0, 7) == 0)
                    word[CFG_DATA_W-1:SHIFT_W] = SHIFT_HI_W'($urandom_range(1, 511));
                write_reg(bmhp_pkg::CFG_DIFF_SHIFT, word);
            end
            for (int k = 0; k < 4; k++)
                tone[k] = PIX_W'($urandom_range(0, PIX_MAX));
            fill = t_fill'($urandom_range(FILL_NOISE, FILL_DIAG_DOWN));
            send_frame(fill);
        end

        // rows beyond the store depth (clamped to it), then a small square plane
        src_gap_max    = GAP_MAX;
        sink_stall_max = GAP_MAX;
        for (int k = 0; k < 4; k++)
            tone[k] = PIX_W'($urandom_range(0, PIX_MAX));
        set_geometry((1 << ROWS_W) - 1, 1, 0);
        send_frame(FILL_NOISE);
        set_geometry(7, 7, 0);
        send_frame(FILL_FEW);

        wait_idle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
